[design/mvz_pkg.sv]
// Shared types and constants of the int8 matrix-vector core with zero point.
package mvz_pkg;

  localparam int unsigned VAL_W     = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CCNT_W    = 11;
  localparam int unsigned RCNT_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic {
    CMD_VEC_LOAD = 1'b0,
    CMD_MAT_ELEM = 1'b1
  } mvz_cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT = 2'd2;

  typedef struct packed {
    logic vld;
    logic row_end;
    logic last;
  } mvz_ctl_t;

endpackage

[design/mvz_ram.sv]
// Generic single-port synchronous RAM with registered read.
module mvz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mvz_mac.sv]
// Multiply-accumulate stage: running dot product and row sum per matrix row.
module mvz_mac #(
  parameter int unsigned RS_W = 19
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  mvz_pkg::mvz_ctl_t               ctl_i,
  input  logic signed [mvz_pkg::VAL_W-1:0] value_i,
  input  logic signed [mvz_pkg::VAL_W-1:0] vec_i,
  input  logic                            down_free_i,
  output logic                            free_o,
  output mvz_pkg::mvz_ctl_t               ctl_o,
  output logic [mvz_pkg::ACC_W-1:0]       dot_o,
  output logic signed [RS_W-1:0]          rsum_o
);

  mvz_pkg::mvz_ctl_t ctl_q, ctl_d;
  logic signed [mvz_pkg::VAL_W-1:0] val_q;
  logic [mvz_pkg::ACC_W-1:0] dot_q, dot_d, dot_nx;
  logic signed [RS_W-1:0] rs_q, rs_d, rs_nx;
  logic signed [2*mvz_pkg::VAL_W-1:0] prod;
  logic go;

  assign prod   = val_q * vec_i;
  assign dot_nx = dot_q + mvz_pkg::ACC_W'(prod);
  assign rs_nx  = rs_q + RS_W'(val_q);

  // a row end waits for room downstream
  assign go     = ctl_q.vld && (!ctl_q.row_end || down_free_i);
  assign free_o = !ctl_q.vld || go;

  always_comb begin
    ctl_d = ctl_q;
    dot_d = dot_q;
    rs_d  = rs_q;
    if (go) begin
      ctl_d.vld = 1'b0;
      if (ctl_q.row_end) begin
        dot_d = '0;
        rs_d  = '0;
      end else begin
        dot_d = dot_nx;
        rs_d  = rs_nx;
      end
    end
    if (load_i) begin
      ctl_d = ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      dot_q <= '0;
      rs_q  <= '0;
    end else begin
      ctl_q <= ctl_d;
      dot_q <= dot_d;
      rs_q  <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= value_i;
    end
  end

  assign ctl_o.vld     = go && ctl_q.row_end;
  assign ctl_o.row_end = ctl_q.row_end;
  assign ctl_o.last    = ctl_q.last;
  assign dot_o         = dot_nx;
  assign rsum_o        = rs_nx;

endmodule

[design/mvz_fin.sv]
// Row finish: subtract zero point times row sum and hold the result for transfer.
module mvz_fin #(
  parameter int unsigned RS_W = 19
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mvz_pkg::mvz_ctl_t                ctl_i,
  input  logic [mvz_pkg::ACC_W-1:0]        dot_i,
  input  logic signed [RS_W-1:0]           rsum_i,
  input  logic signed [mvz_pkg::ACC_W-1:0] zero_point_i,
  output logic                             free_o,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [mvz_pkg::ACC_W-1:0]        result_o,
  output logic                             last_o
);

  logic s2_vld_q, s2_vld_d;
  logic s2_last_q;
  logic [mvz_pkg::ACC_W-1:0] s2_dot_q;
  logic signed [RS_W-1:0] s2_rs_q;
  logic out_vld_q, out_vld_d;
  logic out_last_q;
  logic [mvz_pkg::ACC_W-1:0] out_data_q;
  logic signed [mvz_pkg::ACC_W-1:0] zp_prod;
  logic out_free, s2_go;

  assign zp_prod  = zero_point_i * mvz_pkg::ACC_W'(s2_rs_q);
  assign out_free = !out_vld_q || ready_i;
  assign s2_go    = s2_vld_q && out_free;
  assign free_o   = !s2_vld_q || out_free;

  always_comb begin
    s2_vld_d = s2_vld_q;
    if (s2_go) begin
      s2_vld_d = 1'b0;
    end
    if (ctl_i.vld) begin
      s2_vld_d = 1'b1;
    end
    out_vld_d = out_vld_q;
    if (out_vld_q && ready_i) begin
      out_vld_d = 1'b0;
    end
    if (s2_go) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      s2_dot_q  <= dot_i;
      s2_rs_q   <= rsum_i;
      s2_last_q <= ctl_i.last;
    end
    if (s2_go) begin
      out_data_q <= s2_dot_q - mvz_pkg::ACC_W'(zp_prod);
      out_last_q <= s2_last_q;
    end
  end

  assign valid_o  = out_vld_q;
  assign result_o = out_data_q;
  assign last_o   = out_last_q;

endmodule

[design/int8_matvec_zero_point_core.sv]
// A row's last byte moves through the MAC, finish and output registers; row ends may stall input.
// Throughput: one item per cycle unless stalled; the RAM port serves one write or read per item.
// Vector loads and matrix bytes may be mixed freely; a load is visible to the next byte.
// Reset clears counters, accumulators and pipeline valids; registers return to
// col_count = 1, row_count = 1, zero_point = 0. Vector RAM contents are undefined until written.
module int8_matvec_zero_point_core #(
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [23:0]                         s_axis_tdata_i,  // column[9:0], value[17:10]
  input  logic                                s_axis_tuser_i,  // cmd
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [31:0]                         m_axis_tdata_o,  // row_result[31:0]
  output logic                                m_axis_tlast_o,  // last_row
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mvz_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_COLS);
  localparam int unsigned RS_W  = $clog2(MAX_COLS + 1) + mvz_pkg::VAL_W;
  localparam int unsigned CMP_W = (AW + 1 > mvz_pkg::CCNT_W) ? AW + 1 : mvz_pkg::CCNT_W;

  logic [mvz_pkg::CCNT_W-1:0] col_count_q, col_count_d;
  logic [mvz_pkg::RCNT_W-1:0] row_count_q, row_count_d;
  logic signed [mvz_pkg::ACC_W-1:0] zero_point_q, zero_point_d;
  logic [AW-1:0] col_cnt_q, col_cnt_d;
  logic [mvz_pkg::RCNT_W-1:0] row_cnt_q, row_cnt_d;

  logic [mvz_pkg::COL_W-1:0] in_column;
  logic signed [mvz_pkg::VAL_W-1:0] in_value;
  mvz_pkg::mvz_cmd_e in_cmd;

  logic accept, mat_load, vec_we;
  logic [CMP_W-1:0] eff_cols;
  logic [mvz_pkg::RCNT_W:0] eff_rows;
  logic row_end, mat_last;
  logic [AW-1:0] ram_addr;
  logic [mvz_pkg::VAL_W-1:0] ram_rdata;
  mvz_pkg::mvz_ctl_t s1_ctl, s2_ctl;
  logic mac_free, fin_free;
  logic [mvz_pkg::ACC_W-1:0] mac_dot;
  logic signed [RS_W-1:0] mac_rsum;

  assign in_column = s_axis_tdata_i[mvz_pkg::COL_W-1:0];
  assign in_value  = s_axis_tdata_i[mvz_pkg::COL_W +: mvz_pkg::VAL_W];
  assign in_cmd    = mvz_pkg::mvz_cmd_e'(s_axis_tuser_i);

  assign s_axis_tready_o = mac_free;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign mat_load = accept && (in_cmd == mvz_pkg::CMD_MAT_ELEM);
  // drop vector writes beyond the store
  assign vec_we   = accept && (in_cmd == mvz_pkg::CMD_VEC_LOAD)
                    && (32'(in_column) < 32'(MAX_COLS));

  always_comb begin
    eff_cols = CMP_W'(col_count_q);
    if (col_count_q == '0) begin
      eff_cols = CMP_W'(1);
    end else if (eff_cols > CMP_W'(MAX_COLS)) begin
      eff_cols = CMP_W'(MAX_COLS);
    end
    eff_rows = (row_count_q == '0) ? (mvz_pkg::RCNT_W+1)'(1)
                                   : {1'b0, row_count_q};
  end

  assign row_end  = (CMP_W'(col_cnt_q) + CMP_W'(1)) >= eff_cols;
  assign mat_last = ({1'b0, row_cnt_q} + (mvz_pkg::RCNT_W+1)'(1)) >= eff_rows;
  assign ram_addr = (in_cmd == mvz_pkg::CMD_MAT_ELEM) ? col_cnt_q : AW'(in_column);

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (mat_load) begin
      if (row_end) begin
        col_cnt_d = '0;
        row_cnt_d = mat_last ? '0 : row_cnt_q + mvz_pkg::RCNT_W'(1);
      end else begin
        col_cnt_d = col_cnt_q + AW'(1);
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    col_count_d  = col_count_q;
    row_count_d  = row_count_q;
    zero_point_d = zero_point_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mvz_pkg::CFG_COL_COUNT:  col_count_d  = cfg_data_i[mvz_pkg::CCNT_W-1:0];
        mvz_pkg::CFG_ROW_COUNT:  row_count_d  = cfg_data_i[mvz_pkg::RCNT_W-1:0];
        mvz_pkg::CFG_ZERO_POINT: zero_point_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q  <= mvz_pkg::CCNT_W'(1);
      row_count_q  <= mvz_pkg::RCNT_W'(1);
      zero_point_q <= '0;
      col_cnt_q    <= '0;
      row_cnt_q    <= '0;
    end else begin
      col_count_q  <= col_count_d;
      row_count_q  <= row_count_d;
      zero_point_q <= zero_point_d;
      col_cnt_q    <= col_cnt_d;
      row_cnt_q    <= row_cnt_d;
    end
  end

  assign s1_ctl.vld     = mat_load;
  assign s1_ctl.row_end = row_end;
  assign s1_ctl.last    = mat_last;

  mvz_ram #(
    .WIDTH (mvz_pkg::VAL_W),
    .DEPTH (MAX_COLS)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (vec_we),
    .addr_i  (ram_addr),
    .wdata_i (in_value),
    .rdata_o (ram_rdata)
  );

  mvz_mac #(
    .RS_W (RS_W)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (mat_load),
    .ctl_i       (s1_ctl),
    .value_i     (in_value),
    .vec_i       (ram_rdata),
    .down_free_i (fin_free),
    .free_o      (mac_free),
    .ctl_o       (s2_ctl),
    .dot_o       (mac_dot),
    .rsum_o      (mac_rsum)
  );

  mvz_fin #(
    .RS_W (RS_W)
  ) u_fin (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (s2_ctl),
    .dot_i        (mac_dot),
    .rsum_i       (mac_rsum),
    .zero_point_i (zero_point_q),
    .free_o       (fin_free),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .result_o     (m_axis_tdata_o),
    .last_o       (m_axis_tlast_o)
  );

endmodule
